/* rtl/scrf_pkg.sv */
// scrf_pkg: shared types and constants of the sequence copy ratio filter
// word layouts for the input and result channels, register indexes, defaults
// no dependencies
package scrf_pkg;

  localparam int unsigned FIELD_W   = 16;
  localparam int unsigned FRAC_W    = 9;
  localparam int unsigned RATIO_W   = 24;
  localparam int unsigned SUM_W     = 40;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned MAX_MARKERS_DEF = 65535;
  localparam int unsigned COUNT_BITS_DEF  = 16;

  localparam logic [RATIO_W-1:0] RATIO_SAT = 24'd16776960;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_COPY         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_COPY         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_AVERAGE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LOW_FRACTION = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_HITS         = 3'd4;

  localparam logic [FIELD_W-1:0] MIN_COPY_RST         = 16'd3;
  localparam logic [FIELD_W-1:0] MAX_COPY_RST         = 16'hFFFF;
  localparam logic [FIELD_W-1:0] MIN_AVERAGE_RST      = 16'd0;
  localparam logic [FRAC_W-1:0]  MAX_LOW_FRACTION_RST = 9'd256;
  localparam logic [FIELD_W-1:0] MIN_HITS_RST         = 16'd1;

  typedef struct packed {
    logic [FIELD_W-1:0] reference_count;
    logic [FIELD_W-1:0] sequence_count;
    logic               last_marker;
  } in_word_t;

  typedef struct packed {
    logic [FIELD_W-1:0] marker_total;
    logic [FIELD_W-1:0] low_total;
    logic [FIELD_W-1:0] hit_total;
    logic [RATIO_W-1:0] average_ratio;
    logic               keep;
  } out_word_t;

  function automatic logic [FIELD_W-1:0] clamp16(input logic [31:0] v);
    logic [FIELD_W-1:0] r;
    r = (v > 32'h0000FFFF) ? 16'hFFFF : v[FIELD_W-1:0];
    return r;
  endfunction

endpackage

/* rtl/sequence_copy_ratio_filter_unit.sv */
// sequence_copy_ratio_filter_unit: marker counts, Q.8 copy ratio mean, keep decision
// one shared restoring divider under a small sequencer
// depends on scrf_pkg
//
//   channel | signals                       | word
//   --------+-------------------------------+---------------------------
//   input   | in_valid, in_stall, in_word   | one marker
//   result  | out_valid, out_stall, out_word| totals, mean ratio, keep
//   config  | cfg_valid, cfg_ready          | cfg_index, cfg_data
//
// a marker is handled in order: accept, 24 divider steps for its ratio, one accumulate
// a marker with zero sequence count skips the divider
// the last marker adds 40 divider steps for the mean, one multiply step and the
// emit step, which waits while the previous result is stalled
// synchronous reset restores register defaults and clears the counters
module sequence_copy_ratio_filter_unit #(
  parameter int unsigned MAX_MARKERS = scrf_pkg::MAX_MARKERS_DEF,
  parameter int unsigned COUNT_BITS  = scrf_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  scrf_pkg::in_word_t                  in_word,
  output logic                                out_valid,
  input  logic                                out_stall,
  output scrf_pkg::out_word_t                 out_word,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [scrf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [scrf_pkg::FIELD_W-1:0]        cfg_data
);
  import scrf_pkg::*;

  localparam longint unsigned CntFull  = (64'd1 << COUNT_BITS) - 64'd1;
  localparam longint unsigned CntLim64 =
    (64'(MAX_MARKERS) < CntFull) ? 64'(MAX_MARKERS) : CntFull;
  localparam logic [COUNT_BITS-1:0] CntLimit = CntLim64[COUNT_BITS-1:0];
  localparam int unsigned DVR_W   = (COUNT_BITS > FIELD_W) ? COUNT_BITS : FIELD_W;
  localparam int unsigned PROD_W  = COUNT_BITS + FRAC_W;
  localparam int unsigned STEP_W  = 6;
  localparam logic [STEP_W-1:0] RatioSteps = STEP_W'(RATIO_W - 1);
  localparam logic [STEP_W-1:0] AvgSteps   = STEP_W'(SUM_W - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_RATIO, S_ACC, S_AVG, S_MULT, S_EMIT
  } state_t;

  state_t state;

  logic [FIELD_W-1:0]    min_copy;
  logic [FIELD_W-1:0]    max_copy;
  logic [FIELD_W-1:0]    min_average;
  logic [FRAC_W-1:0]     max_low_fraction;
  logic [FIELD_W-1:0]    min_hits;

  logic [COUNT_BITS-1:0] marker_counter;
  logic [COUNT_BITS-1:0] low_counter;
  logic [COUNT_BITS-1:0] hit_counter;
  logic [SUM_W-1:0]      ratio_sum;
  logic                  last_q;

  logic [SUM_W-1:0]      quo;
  logic [DVR_W-1:0]      rem;
  logic [DVR_W-1:0]      dvs;
  logic [STEP_W-1:0]     step;

  logic [PROD_W-1:0]     frac_lhs;
  logic [PROD_W-1:0]     frac_rhs;
  logic [RATIO_W-1:0]    avg_q;

  logic                  in_take;
  logic                  out_free;
  logic [DVR_W:0]        div_shift;
  logic                  div_ge;
  logic [DVR_W:0]        div_diff;
  logic [DVR_W-1:0]      div_rem_next;
  logic [SUM_W:0]        sum_add;
  logic [FIELD_W-1:0]    hits_needed;
  logic                  keep_next;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // shared restoring divider step
  assign div_shift    = {rem, quo[SUM_W-1]};
  assign div_ge       = (div_shift >= {1'b0, dvs});
  assign div_diff     = div_shift - {1'b0, dvs};
  assign div_rem_next = div_ge ? div_diff[DVR_W-1:0] : div_shift[DVR_W-1:0];

  assign sum_add     = {1'b0, ratio_sum} + (SUM_W + 1)'(quo[RATIO_W-1:0]);
  assign hits_needed = (min_hits == '0) ? FIELD_W'(1) : min_hits;
  assign keep_next   = (32'(hit_counter) >= 32'(hits_needed))
                    && (frac_lhs <= frac_rhs)
                    && (avg_q >= {min_average, 8'd0});

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      min_copy         <= MIN_COPY_RST;
      max_copy         <= MAX_COPY_RST;
      min_average      <= MIN_AVERAGE_RST;
      max_low_fraction <= MAX_LOW_FRACTION_RST;
      min_hits         <= MIN_HITS_RST;
      marker_counter   <= '0;
      low_counter      <= '0;
      hit_counter      <= '0;
      ratio_sum        <= '0;
      last_q           <= 1'b0;
      step             <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MIN_COPY:         min_copy         <= cfg_data;
          REG_MAX_COPY:         max_copy         <= cfg_data;
          REG_MIN_AVERAGE:      min_average      <= cfg_data;
          REG_MAX_LOW_FRACTION: max_low_fraction <= cfg_data[FRAC_W-1:0];
          REG_MIN_HITS:         min_hits         <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            last_q <= in_word.last_marker;
            if (marker_counter < CntLimit) begin
              marker_counter <= marker_counter + 1'b1;
            end
            if (in_word.reference_count < min_copy) begin
              if (low_counter < CntLimit) begin
                low_counter <= low_counter + 1'b1;
              end
            end else if (in_word.reference_count <= max_copy) begin
              if (hit_counter < CntLimit) begin
                hit_counter <= hit_counter + 1'b1;
              end
            end
            rem <= '0;
            dvs <= DVR_W'(in_word.sequence_count);
            if (in_word.sequence_count == '0) begin
              quo   <= SUM_W'(RATIO_SAT);
              state <= S_ACC;
            end else begin
              quo   <= {in_word.reference_count, (SUM_W - FIELD_W)'(0)};
              step  <= RatioSteps;
              state <= S_RATIO;
            end
          end
        end
        S_RATIO, S_AVG: begin
          rem  <= div_rem_next;
          quo  <= {quo[SUM_W-2:0], div_ge};
          step <= step - 1'b1;
          if (step == '0) begin
            state <= (state == S_RATIO) ? S_ACC : S_MULT;
          end
        end
        S_ACC: begin
          ratio_sum <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
          if (last_q) begin
            quo   <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
            rem   <= '0;
            dvs   <= DVR_W'(marker_counter);
            step  <= AvgSteps;
            state <= S_AVG;
          end else begin
            state <= S_IDLE;
          end
        end
        S_MULT: begin
          avg_q    <= (quo[SUM_W-1:RATIO_W] != '0) ? '1 : quo[RATIO_W-1:0];
          frac_lhs <= PROD_W'({low_counter, 8'd0});
          frac_rhs <= PROD_W'(max_low_fraction) * PROD_W'(marker_counter);
          state    <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid              <= 1'b1;
            out_word.marker_total  <= clamp16(32'(marker_counter));
            out_word.low_total     <= clamp16(32'(low_counter));
            out_word.hit_total     <= clamp16(32'(hit_counter));
            out_word.average_ratio <= avg_q;
            out_word.keep          <= keep_next;
            marker_counter         <= '0;
            low_counter            <= '0;
            hit_counter            <= '0;
            ratio_sum              <= '0;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// testbench: self-checking bench for sequence_copy_ratio_filter_unit
// drives marker words, predicts per-sequence summaries, compares result words field by field
// depends on scrf_pkg and the unit's rtl
module testbench;
  import scrf_pkg::*;

  localparam longint unsigned CNT_LIMIT =
    (MAX_MARKERS_DEF < ((64'd1 << COUNT_BITS_DEF) - 1)) ?
    MAX_MARKERS_DEF : ((64'd1 << COUNT_BITS_DEF) - 1);
  localparam logic [63:0] SUM_LIMIT = (64'd1 << SUM_W) - 1;
  localparam logic [63:0] AVG_LIMIT = (64'd1 << RATIO_W) - 1;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = REG_MIN_HITS + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_IDX = '1;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned HOLD_CYCLES = 600;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FIELD_W-1:0] cfg_data = '0;

  // register copies
  logic [FIELD_W-1:0] cfg_min_copy = MIN_COPY_RST;
  logic [FIELD_W-1:0] cfg_max_copy = MAX_COPY_RST;
  logic [FIELD_W-1:0] cfg_min_average = MIN_AVERAGE_RST;
  logic [FRAC_W-1:0] cfg_max_low_fraction = MAX_LOW_FRACTION_RST;
  logic [FIELD_W-1:0] cfg_min_hits = MIN_HITS_RST;

  // running sequence tallies
  logic [63:0] mark_cnt = '0;
  logic [63:0] low_cnt = '0;
  logic [63:0] hit_cnt = '0;
  logic [63:0] ratio_acc = '0;

  in_word_t marker_q[$];
  out_word_t summary_q[$];

  int unsigned send_pct = 0;
  int unsigned recv_pct = 0;
  logic hold_start = 1'b0;
  int unsigned hold_left = 0;

  int unsigned errors = 0;
  int unsigned markers_sent = 0;
  int unsigned summaries_seen = 0;
  int unsigned kept_seen = 0;
  int unsigned reg_writes = 0;

  sequence_copy_ratio_filter_unit DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [FIELD_W-1:0] clip_total(input logic [63:0] v);
    return (v > 64'hFFFF) ? 16'hFFFF : v[FIELD_W-1:0];
  endfunction

  // fold one accepted marker into the tallies, queue a summary on the last one
  function automatic void account_marker(input in_word_t w);
    logic [63:0] ratio;
    logic [63:0] avg;
    logic [63:0] hits_needed;
    out_word_t s;
    ratio = (w.sequence_count == 0) ? 64'(RATIO_SAT) :
            ({48'd0, w.reference_count} << 8) / w.sequence_count;
    if (mark_cnt < CNT_LIMIT) mark_cnt = mark_cnt + 1;
    if (w.reference_count < cfg_min_copy) begin
      if (low_cnt < CNT_LIMIT) low_cnt = low_cnt + 1;
    end else if (w.reference_count <= cfg_max_copy) begin
      if (hit_cnt < CNT_LIMIT) hit_cnt = hit_cnt + 1;
    end
    ratio_acc = ratio_acc + ratio;
    if (ratio_acc > SUM_LIMIT) ratio_acc = SUM_LIMIT;
    if (!w.last_marker) return;
    avg = ratio_acc / mark_cnt;
    if (avg > AVG_LIMIT) avg = AVG_LIMIT;
    hits_needed = (cfg_min_hits == 0) ? 64'd1 : 64'(cfg_min_hits);
    s.marker_total = clip_total(mark_cnt);
    s.low_total = clip_total(low_cnt);
    s.hit_total = clip_total(hit_cnt);
    s.average_ratio = avg[RATIO_W-1:0];
    s.keep = (hit_cnt >= hits_needed)
          && ((low_cnt << 8) <= 64'(cfg_max_low_fraction) * mark_cnt)
          && (avg >= (64'(cfg_min_average) << 8));
    summary_q.push_back(s);
    mark_cnt = '0;
    low_cnt = '0;
    hit_cnt = '0;
    ratio_acc = '0;
  endfunction

  function automatic void note_mismatch(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    errors++;
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endfunction

  // marker driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) account_marker(in_word);
      if (!in_valid || !in_stall) begin
        if (marker_q.size() != 0 && $urandom_range(99) >= send_pct) begin
          in_word <= marker_q.pop_front();
          in_valid <= 1'b1;
          markers_sent++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_start) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // summary monitor
  always @(posedge clk) begin : summary_monitor
    out_word_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        summaries_seen++;
        if (summary_q.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected summary word, expected none, actual %p", $time, out_word);
        end else begin
          want = summary_q.pop_front();
          if (want.keep) kept_seen++;
          if (out_word.marker_total !== want.marker_total)
            note_mismatch("marker_total", want.marker_total, out_word.marker_total);
          if (out_word.low_total !== want.low_total)
            note_mismatch("low_total", want.low_total, out_word.low_total);
          if (out_word.hit_total !== want.hit_total)
            note_mismatch("hit_total", want.hit_total, out_word.hit_total);
          if (out_word.average_ratio !== want.average_ratio)
            note_mismatch("average_ratio", want.average_ratio, out_word.average_ratio);
          if (out_word.keep !== want.keep)
            note_mismatch("keep", want.keep, out_word.keep);
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_pct);
    end
  end

  task automatic add_marker(input logic [FIELD_W-1:0] nr, input logic [FIELD_W-1:0] ns,
                            input logic last);
    in_word_t w;
    w.reference_count = nr;
    w.sequence_count = ns;
    w.last_marker = last;
    marker_q.push_back(w);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_writes++;
    case (idx)
      REG_MIN_COPY: cfg_min_copy = data;
      REG_MAX_COPY: cfg_max_copy = data;
      REG_MIN_AVERAGE: cfg_min_average = data;
      REG_MAX_LOW_FRACTION: cfg_max_low_fraction = data[FRAC_W-1:0];
      REG_MIN_HITS: cfg_min_hits = data;
      default: ;
    endcase
  endtask

  task automatic wait_drained;
    do @(negedge clk); while (marker_q.size() != 0 || in_valid || summary_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_idling(input int unsigned s, input int unsigned r);
    @(posedge clk);
    send_pct <= s;
    recv_pct <= r;
  endtask

  function automatic logic [FIELD_W-1:0] pick_reference();
    logic [FIELD_W-1:0] r;
    case ($urandom_range(5))
      0: r = '0;
      1: r = '1;
      2: r = cfg_min_copy - 16'd1;
      3: r = cfg_min_copy;
      4: r = cfg_max_copy + 16'($urandom_range(1));
      default: r = 16'($urandom_range(65535));
    endcase
    return r;
  endfunction

  function automatic logic [FIELD_W-1:0] pick_sequence();
    logic [FIELD_W-1:0] r;
    case ($urandom_range(9))
      0: r = '0;
      1: r = '1;
      2, 3, 4: r = 16'($urandom_range(8, 1));
      default: r = 16'($urandom_range(65535));
    endcase
    return r;
  endfunction

  task automatic push_sequences(input int unsigned n_items);
    int unsigned count;
    int unsigned len;
    count = 0;
    while (count < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(6, 1);
      for (int unsigned i = 0; i < len; i++)
        add_marker(pick_reference(), pick_sequence(), i == len - 1);
      count += len;
    end
  endtask

  task automatic random_config;
    cfg_write(REG_MIN_COPY, ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(8)));
    cfg_write(REG_MAX_COPY, ($urandom_range(2) == 0) ? 16'hFFFF : 16'($urandom));
    cfg_write(REG_MIN_AVERAGE,
              ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(2)));
    cfg_write(REG_MAX_LOW_FRACTION,
              ($urandom_range(3) == 0) ? 16'($urandom_range(511)) : 16'($urandom_range(256)));
    cfg_write(REG_MIN_HITS, ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(4)));
    if ($urandom_range(3) == 0) cfg_write(REG_UNMAPPED + 3'($urandom_range(2)), 16'($urandom));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // defaults: saturated ratio, field extremes, rounding, alternating bits
    @(negedge clk);
    add_marker(16'd0, 16'd0, 1'b1);
    add_marker(16'hFFFF, 16'd1, 1'b0);
    add_marker(16'hFFFF, 16'hFFFF, 1'b0);
    add_marker(16'd3, 16'd2, 1'b0);
    add_marker(16'd2, 16'hFFFF, 1'b1);
    add_marker(16'd1, 16'd3, 1'b1);
    add_marker(16'hAAAA, 16'h5555, 1'b0);
    add_marker(16'h5555, 16'hAAAA, 1'b1);
    wait_drained;

    // min copy above max copy, zero min hits, strictest average and fraction
    cfg_write(REG_MIN_COPY, 16'hFFFF);
    cfg_write(REG_MAX_COPY, 16'd0);
    cfg_write(REG_MIN_AVERAGE, 16'hFFFF);
    cfg_write(REG_MAX_LOW_FRACTION, 16'd0);
    cfg_write(REG_MIN_HITS, 16'd0);
    cfg_write(REG_UNMAPPED, 16'h1234);
    cfg_write(REG_TOP_IDX, 16'hFFFF);
    @(negedge clk);
    add_marker(16'hFFFE, 16'd1, 1'b0);
    add_marker(16'hFFFF, 16'd0, 1'b1);
    add_marker(16'd0, 16'd1, 1'b1);
    wait_drained;

    // low fraction above one
    cfg_write(REG_MIN_COPY, 16'd5);
    cfg_write(REG_MAX_COPY, 16'hFFFF);
    cfg_write(REG_MIN_AVERAGE, 16'd1);
    cfg_write(REG_MAX_LOW_FRACTION, 16'd300);
    cfg_write(REG_MIN_HITS, 16'd1);
    @(negedge clk);
    add_marker(16'd0, 16'd1, 1'b0);
    add_marker(16'd0, 16'd1, 1'b0);
    add_marker(16'd1000, 16'd1, 1'b1);
    wait_drained;

    cfg_write(REG_MIN_COPY, 16'd0);
    cfg_write(REG_MIN_AVERAGE, 16'd0);
    cfg_write(REG_MAX_LOW_FRACTION, 16'd511);
    cfg_write(REG_MIN_HITS, 16'hFFFF);
    @(negedge clk);
    add_marker(16'hFFFF, 16'hFFFF, 1'b1);
    add_marker(16'd7, 16'd7, 1'b1);
    wait_drained;

    // random sequences under three idling patterns
    for (int unsigned mode = 0; mode < 3; mode++) begin
      case (mode)
        0: set_idling(17, 64);
        1: set_idling(64, 17);
        default: set_idling(0, 0);
      endcase
      for (int unsigned part = 0; part < 2; part++) begin
        random_config();
        if (mode == 2 && part == 0) begin
          @(posedge clk);
          hold_start <= 1'b1;
          @(posedge clk);
          hold_start <= 1'b0;
        end
        @(negedge clk);
        push_sequences(108);
        wait_drained;
      end
    end

    $display("run covered %0d markers and %0d sequence summaries (%0d kept)",
             markers_sent, summaries_seen, kept_seen);
    $display("with %0d register writes across directed, idling and hold-off phases",
             reg_writes);
    if (errors == 0 && summary_q.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

/* filelist.f */
rtl/scrf_pkg.sv
rtl/sequence_copy_ratio_filter_unit.sv
tb/sv/testbench.sv
